FILE: hdl/ors_pkg.sv
// ors_pkg: types, codes and constants shared by the update receive sequencer
// no dependencies; compiled first
package ors_pkg;

	localparam int unsigned MAX_RESULTS = 3;
	localparam int unsigned FIFO_DEPTH  = 4;
	localparam int unsigned TICK_W      = 24;
	localparam int unsigned CFG_IDX_W   = 3;

	typedef enum logic [3:0] {
		ACT_REQ      = 4'd0,
		ACT_READY    = 4'd1,
		ACT_DONE     = 4'd2,
		ACT_ERROR    = 4'd3,
		ACT_ERASE    = 4'd4,
		ACT_WRITE    = 4'd5,
		ACT_FINISH   = 4'd6,
		ACT_SRESET   = 4'd7,
		ACT_SYSRESET = 4'd8
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACK_TIMEOUT  = 3'd0,
		CFG_DATA_TIMEOUT = 3'd1,
		CFG_BACKOFF      = 3'd2,
		CFG_CRC_LIMIT    = 3'd3,
		CFG_MAX_IMAGE    = 3'd4
	} cfg_idx_t;

	typedef enum logic [6:0] {
		PH_IDLE        = 7'b0000001,
		PH_WAIT_ACK    = 7'b0000010,
		PH_WAIT_ERASE  = 7'b0000100,
		PH_RECV        = 7'b0001000,
		PH_WAIT_WRITE  = 7'b0010000,
		PH_WAIT_FINISH = 7'b0100000,
		PH_DONE        = 7'b1000000
	} phase_t;

	typedef enum logic [1:0] {
		REQ_TICK   = 2'd0,
		REQ_FRAME  = 2'd1,
		REQ_STATUS = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		FK_ACK   = 2'd0,
		FK_DATA  = 2'd1,
		FK_END   = 2'd2,
		FK_OTHER = 2'd3
	} frame_kind_t;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_SIZE_BAD = 3'd2;
	localparam logic [2:0] ST_CRC_BAD  = 3'd3;

	localparam logic [31:0] ERR_SEQ     = 32'd2;
	localparam logic [31:0] ERR_FLASH   = 32'd3;
	localparam logic [31:0] ERR_TIMEOUT = 32'd4;
	localparam logic [31:0] ERR_SIZE    = 32'd5;
	localparam logic [31:0] ERR_CRC     = 32'd6;

	typedef struct packed {
		logic [TICK_W-1:0] ack_timeout;
		logic [TICK_W-1:0] data_timeout;
		logic [TICK_W-1:0] backoff;
		logic [3:0]        crc_limit;
		logic [31:0]       max_image;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [1:0]  frame_kind;
		logic [7:0]  frame_len;
		logic [31:0] frame_word;
		logic [2:0]  storage_status;
	} in_item_t;

	typedef struct packed {
		phase_t            phase;
		logic [TICK_W-1:0] elapsed;
		logic              backoff_pending;
		logic [15:0]       exp_seq;
		logic [3:0]        crc_fails;
	} seq_state_t;

	typedef struct packed {
		action_t     action;
		logic [31:0] value;
	} result_t;

	typedef struct packed {
		action_t     action;
		logic [31:0] value;
		logic        last;
	} out_entry_t;

	typedef struct packed {
		seq_state_t                       nxt;
		logic [1:0]                       n;
		result_t [MAX_RESULTS-1:0]        ent;
	} step_res_t;

endpackage

FILE: hdl/ors_if.sv
// ors_if: valid/ready channel interfaces for items, results and register writes
// no dependencies
interface ors_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [1:0]  frame_kind;
	logic [7:0]  frame_len;
	logic [31:0] frame_word;
	logic [2:0]  storage_status;

	modport source (output valid, req_type, frame_kind, frame_len, frame_word,
		storage_status, input ready);
	modport sink (input valid, req_type, frame_kind, frame_len, frame_word,
		storage_status, output ready);
endinterface

interface ors_res_if;
	logic        valid;
	logic        ready;
	logic [3:0]  action;
	logic [31:0] action_value;
	logic        last_action;

	modport source (output valid, action, action_value, last_action, input ready);
	modport sink (input valid, action, action_value, last_action, output ready);
endinterface

interface ors_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  reg_index;
	logic [31:0] wr_data;

	modport source (output valid, reg_index, wr_data, input ready);
	modport sink (input valid, reg_index, wr_data, output ready);
endinterface

FILE: hdl/ors_step.sv
// ors_step: next-state and result logic for one registered transaction
// depends on ors_pkg
module ors_step import ors_pkg::*; (
	input  cfg_t       cfg,
	input  seq_state_t st,
	input  in_item_t   item,
	output step_res_t  res
);

	logic [TICK_W-1:0] tick_inc;
	logic [TICK_W-1:0] idle_el;
	logic              fail;
	logic [31:0]       code;
	logic [3:0]        crc_next;

	assign tick_inc = (st.elapsed == '1) ? st.elapsed : st.elapsed + 1'b1;
	assign idle_el  = st.backoff_pending ? tick_inc : st.elapsed;
	assign crc_next = st.crc_fails + 1'b1;

	always_comb begin
		res     = '0;
		res.nxt = st;
		fail    = 1'b0;
		code    = '0;
		case (st.phase)
			PH_IDLE: begin
				if (item.req_type == REQ_TICK) begin
					res.nxt.elapsed = idle_el;
					if (!st.backoff_pending || idle_el >= cfg.backoff) begin
						res.ent[0]              = '{action: ACT_REQ, value: '0};
						res.n                   = 2'd1;
						res.nxt.backoff_pending = 1'b0;
						res.nxt.elapsed         = '0;
						res.nxt.phase           = PH_WAIT_ACK;
					end
				end
			end
			PH_WAIT_ACK: begin
				if (item.req_type == REQ_TICK) begin
					res.nxt.elapsed = tick_inc;
					if (tick_inc >= cfg.ack_timeout) begin
						fail = 1'b1;
						code = ERR_TIMEOUT;
					end
				end else if (item.req_type == REQ_FRAME && item.frame_kind == FK_ACK
						&& item.frame_len >= 8'd4) begin
					if (item.frame_word == '0 || item.frame_word > cfg.max_image) begin
						fail = 1'b1;
						code = ERR_FLASH;
					end else begin
						res.ent[0]    = '{action: ACT_ERASE, value: item.frame_word};
						res.n         = 2'd1;
						res.nxt.phase = PH_WAIT_ERASE;
					end
				end
			end
			PH_WAIT_ERASE: begin
				if (item.req_type == REQ_STATUS) begin
					if (item.storage_status != ST_OK) begin
						fail = 1'b1;
						code = ERR_FLASH;
					end else begin
						res.ent[0]        = '{action: ACT_READY, value: '0};
						res.n             = 2'd1;
						res.nxt.exp_seq   = '0;
						res.nxt.crc_fails = '0;
						res.nxt.elapsed   = '0;
						res.nxt.phase     = PH_RECV;
					end
				end
			end
			PH_RECV: begin
				if (item.req_type == REQ_TICK) begin
					res.nxt.elapsed = tick_inc;
					if (tick_inc >= cfg.data_timeout) begin
						fail = 1'b1;
						code = ERR_TIMEOUT;
					end
				end else if (item.req_type == REQ_FRAME && item.frame_kind == FK_DATA
						&& item.frame_len >= 8'd2) begin
					if (item.frame_word[15:0] != st.exp_seq) begin
						fail = 1'b1;
						code = ERR_SEQ;
					end else begin
						res.ent[0]    = '{action: ACT_WRITE,
							value: {24'd0, 8'(item.frame_len - 8'd2)}};
						res.n         = 2'd1;
						res.nxt.phase = PH_WAIT_WRITE;
					end
				end else if (item.req_type == REQ_FRAME && item.frame_kind == FK_END
						&& item.frame_len >= 8'd4) begin
					res.ent[0]    = '{action: ACT_FINISH, value: item.frame_word};
					res.n         = 2'd1;
					res.nxt.phase = PH_WAIT_FINISH;
				end
			end
			PH_WAIT_WRITE: begin
				if (item.req_type == REQ_STATUS) begin
					if (item.storage_status != ST_OK) begin
						fail = 1'b1;
						code = ERR_FLASH;
					end else begin
						res.nxt.exp_seq = st.exp_seq + 1'b1;
						res.nxt.elapsed = '0;
						res.nxt.phase   = PH_RECV;
					end
				end
			end
			PH_WAIT_FINISH: begin
				if (item.req_type == REQ_STATUS) begin
					if (item.storage_status == ST_OK) begin
						res.ent[0]    = '{action: ACT_DONE, value: '0};
						res.ent[1]    = '{action: ACT_SYSRESET, value: '0};
						res.n         = 2'd2;
						res.nxt.phase = PH_DONE;
					end else if (item.storage_status == ST_SIZE_BAD) begin
						fail = 1'b1;
						code = ERR_SIZE;
					end else if (item.storage_status == ST_CRC_BAD) begin
						fail = 1'b1;
						code = ERR_CRC;
					end else begin
						fail = 1'b1;
						code = ERR_FLASH;
					end
				end
			end
			default: ;
		endcase

		// error path: report, reset storage and back off, unless the crc limit is hit
		if (fail) begin
			res.ent[0]      = '{action: ACT_ERROR, value: code};
			res.nxt.elapsed = '0;
			res.nxt.phase   = PH_IDLE;
			if (code == ERR_CRC && crc_next >= cfg.crc_limit) begin
				res.nxt.crc_fails       = '0;
				res.nxt.backoff_pending = 1'b0;
				res.n                   = 2'd1;
			end else begin
				if (code == ERR_CRC) begin
					res.nxt.crc_fails = crc_next;
				end
				res.ent[1]              = '{action: ACT_SRESET, value: '0};
				res.nxt.backoff_pending = 1'b1;
				res.n                   = 2'd2;
			end
		end
	end

endmodule

FILE: hdl/ors_result_fifo.sv
// ors_result_fifo: small result queue taking up to three entries per cycle
// depends on ors_pkg
module ors_result_fifo import ors_pkg::*; #(
	parameter int unsigned Depth = FIFO_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [1:0]                    push_n,
	input  result_t [MAX_RESULTS-1:0]     push_ent,
	input  logic                          pop,
	output out_entry_t                    head,
	output logic [$clog2(Depth+1)-1:0]    count
);

	localparam int unsigned PtrW = $clog2(Depth);
	localparam int unsigned CntW = $clog2(Depth+1);

	out_entry_t          mem_q [Depth];
	logic [PtrW-1:0]     wr_ptr_q;
	logic [PtrW-1:0]     rd_ptr_q;
	logic [CntW-1:0]     count_q;

	function automatic logic [PtrW-1:0] ptr_add(input logic [PtrW-1:0] p,
			input logic [1:0] k);
		logic [PtrW+1:0] s;
		s = {2'b00, p} + {{PtrW{1'b0}}, k};
		if (s >= (PtrW+2)'(Depth)) begin
			s = s - (PtrW+2)'(Depth);
		end
		return s[PtrW-1:0];
	endfunction

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RESULTS; i++) begin
			if (2'(i) < push_n) begin
				mem_q[ptr_add(wr_ptr_q, 2'(i))] <= '{action: push_ent[i].action,
					value: push_ent[i].value, last: (2'(i) == push_n - 2'd1)};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= ptr_add(wr_ptr_q, push_n);
			if (pop) begin
				rd_ptr_q <= ptr_add(rd_ptr_q, 2'd1);
			end
			count_q <= count_q + CntW'(push_n) - CntW'(pop);
		end
	end

	assign head  = mem_q[rd_ptr_q];
	assign count = count_q;

endmodule

FILE: hdl/ota_receive_sequencer.sv
// ota_receive_sequencer: top level of the update receive sequencer
// depends on ors_pkg, ors_if, ors_step and ors_result_fifo
//
// Usage: req_ch carries ticks, decoded frames and storage status reports;
// res_ch returns the actions (request, ready, erase, write, finish, error,
// storage reset, done, system reset), each with its value and a last flag
// on the final action caused by one transaction. cfg_ch writes the five
// registers by index and is always ready; write only while idle.
// Path: a transaction accepted into the input register is processed once the
// result queue has room, and its actions then wait in the queue for res_ch.
// Throughput: one transaction per cycle while the result queue has room for
// three entries; actions leave one per cycle while res_ch is ready.
// Reset: registers return to their defaults, the sequence goes idle with no
// backoff pending and the queue empties.
// Stall: when res_ch is held off the queue fills, the input register holds
// its transaction and req_ch.ready drops; nothing is lost or reordered.
module ota_receive_sequencer import ors_pkg::*; #(
	parameter int unsigned FifoDepth = FIFO_DEPTH
) (
	input logic        clk,
	input logic        arst_n,
	ors_req_if.sink    req_ch,
	ors_res_if.source  res_ch,
	ors_cfg_if.sink    cfg_ch
);

	localparam int unsigned CntW = $clog2(FifoDepth+1);

	cfg_t            cfg_q;
	seq_state_t      state_q;
	in_item_t        item_s1;
	logic            valid_s1;
	logic            room;
	logic            process;
	step_res_t       step;
	out_entry_t      head;
	logic [CntW-1:0] count;
	logic            pop;

	// configuration
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ack_timeout  <= TICK_W'(5000);
			cfg_q.data_timeout <= TICK_W'(30000);
			cfg_q.backoff      <= TICK_W'(5000);
			cfg_q.crc_limit    <= 4'd3;
			cfg_q.max_image    <= 32'd2097152;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.reg_index)
				CFG_ACK_TIMEOUT:  cfg_q.ack_timeout  <= cfg_ch.wr_data[TICK_W-1:0];
				CFG_DATA_TIMEOUT: cfg_q.data_timeout <= cfg_ch.wr_data[TICK_W-1:0];
				CFG_BACKOFF:      cfg_q.backoff      <= cfg_ch.wr_data[TICK_W-1:0];
				CFG_CRC_LIMIT:    cfg_q.crc_limit    <= cfg_ch.wr_data[3:0];
				CFG_MAX_IMAGE:    cfg_q.max_image    <= cfg_ch.wr_data;
				default: ;
			endcase
		end
	end

	// input register
	assign room          = (count <= CntW'(FifoDepth - MAX_RESULTS));
	assign process       = valid_s1 && room;
	assign req_ch.ready  = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ch.ready) begin
			valid_s1 <= req_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ch.valid && req_ch.ready) begin
			item_s1 <= '{req_type: req_ch.req_type, frame_kind: req_ch.frame_kind,
				frame_len: req_ch.frame_len, frame_word: req_ch.frame_word,
				storage_status: req_ch.storage_status};
		end
	end

	ors_step u_step (
		.cfg  (cfg_q),
		.st   (state_q),
		.item (item_s1),
		.res  (step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_IDLE, elapsed: '0, backoff_pending: 1'b0,
				exp_seq: '0, crc_fails: '0};
		end else if (process) begin
			state_q <= step.nxt;
		end
	end

	// result queue
	assign pop = res_ch.valid && res_ch.ready;

	ors_result_fifo #(
		.Depth (FifoDepth)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_n   (process ? step.n : 2'd0),
		.push_ent (step.ent),
		.pop      (pop),
		.head     (head),
		.count    (count)
	);

	assign res_ch.valid        = (count != '0);
	assign res_ch.action       = head.action;
	assign res_ch.action_value = head.value;
	assign res_ch.last_action  = head.last;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CntW'(FifoDepth))
		else $error("result queue over capacity");

	a_room_on_process: assert property (@(posedge clk) disable iff (!arst_n)
		process |=> count <= CntW'(FifoDepth))
		else $error("processed transaction overran the result queue");

	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q.phase))
		else $error("phase register not one-hot");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_DONE |=> state_q.phase == PH_DONE)
		else $error("left the done phase without reset");

	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(process && state_q.phase == PH_DONE) |-> step.n == 2'd0)
		else $error("action produced after done");

endmodule

FILE: sim/testbench.sv
// testbench: self-checking bench for ota_receive_sequencer, random and directed transactions
// depends on ors_pkg, ors_if and the ota_receive_sequencer rtl; checks every action in order
module testbench;
	import ors_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 250000;
	localparam int unsigned SETTLE       = 6;
	localparam int unsigned HOLD_CYCLES  = 80;
	localparam int unsigned MIN_SIZED    = 4;
	localparam int unsigned MIN_DATA     = 2;
	localparam logic [2:0]  ST_WRITE_BAD = 3'd1;
	localparam logic [2:0]  ST_FLAG_BAD  = 3'd4;
	localparam logic [2:0]  ST_ODD_CODE  = 3'd7;

	logic clk;
	logic arst_n = 1'b0;

	logic        offer      = 1'b0;
	in_item_t    offer_item = '0;
	logic        accept_res = 1'b0;
	logic        cfg_valid  = 1'b0;
	logic [2:0]  cfg_index  = '0;
	logic [31:0] cfg_data   = '0;

	logic        calm      = 1'b0;
	logic        hold_go   = 1'b0;
	logic        held_once = 1'b0;
	int unsigned hold_left = 0;
	int unsigned gap_left  = 0;
	int unsigned stall_left = 0;
	int unsigned cycles    = 0;

	int unsigned error_count     = 0;
	int unsigned items_accepted  = 0;
	int unsigned actions_checked = 0;
	int unsigned error_actions   = 0;
	int unsigned images_done     = 0;
	int unsigned reg_writes      = 0;

	cfg_t       regs;
	seq_state_t plan;
	seq_state_t live;
	in_item_t   pending_items[$];
	out_entry_t expected_actions[$];
	out_entry_t step_actions[$];

	ors_req_if req_ch ();
	ors_res_if res_ch ();
	ors_cfg_if cfg_ch ();

	assign req_ch.valid          = offer;
	assign req_ch.req_type       = offer_item.req_type;
	assign req_ch.frame_kind     = offer_item.frame_kind;
	assign req_ch.frame_len      = offer_item.frame_len;
	assign req_ch.frame_word     = offer_item.frame_word;
	assign req_ch.storage_status = offer_item.storage_status;
	assign res_ch.ready          = accept_res;
	assign cfg_ch.valid          = cfg_valid;
	assign cfg_ch.reg_index      = cfg_index;
	assign cfg_ch.wr_data        = cfg_data;

	ota_receive_sequencer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req_ch (req_ch),
		.res_ch (res_ch),
		.cfg_ch (cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [TICK_W-1:0] tick_up(input logic [TICK_W-1:0] t);
		return (t == '1) ? t : t + 1'b1;
	endfunction

	function automatic void note_action(input action_t a, input logic [31:0] v);
		out_entry_t e;
		e.action = a;
		e.value  = v;
		e.last   = 1'b0;
		step_actions.push_back(e);
	endfunction

	function automatic void raise_error(inout seq_state_t s, input logic [31:0] code);
		note_action(ACT_ERROR, code);
		s.elapsed = '0;
		s.phase   = PH_IDLE;
		if (code == ERR_CRC) s.crc_fails = s.crc_fails + 1'b1;
		if (code == ERR_CRC && s.crc_fails >= regs.crc_limit) begin
			s.crc_fails       = '0;
			s.backoff_pending = 1'b0;
		end else begin
			note_action(ACT_SRESET, '0);
			s.backoff_pending = 1'b1;
		end
	endfunction

	// one transaction through the sequencer, actions appended to step_actions
	function automatic void advance_sequencer(inout seq_state_t s, input in_item_t it);
		out_entry_t tail;
		logic       is_tick;
		logic       is_status;
		logic       is_frame;
		is_tick   = (it.req_type == REQ_TICK);
		is_status = (it.req_type == REQ_STATUS);
		is_frame  = (it.req_type == REQ_FRAME);
		case (s.phase)
		PH_IDLE: if (is_tick) begin
			if (s.backoff_pending) s.elapsed = tick_up(s.elapsed);
			if (!s.backoff_pending || s.elapsed >= regs.backoff) begin
				note_action(ACT_REQ, '0);
				s.backoff_pending = 1'b0;
				s.elapsed         = '0;
				s.phase           = PH_WAIT_ACK;
			end
		end
		PH_WAIT_ACK: if (is_tick) begin
			s.elapsed = tick_up(s.elapsed);
			if (s.elapsed >= regs.ack_timeout) raise_error(s, ERR_TIMEOUT);
		end else if (is_frame && it.frame_kind == FK_ACK && it.frame_len >= MIN_SIZED) begin
			if (it.frame_word == '0 || it.frame_word > regs.max_image) begin
				raise_error(s, ERR_FLASH);
			end else begin
				note_action(ACT_ERASE, it.frame_word);
				s.phase = PH_WAIT_ERASE;
			end
		end
		PH_WAIT_ERASE: if (is_status) begin
			if (it.storage_status != ST_OK) begin
				raise_error(s, ERR_FLASH);
			end else begin
				note_action(ACT_READY, '0);
				s.exp_seq   = '0;
				s.crc_fails = '0;
				s.elapsed   = '0;
				s.phase     = PH_RECV;
			end
		end
		PH_RECV: if (is_tick) begin
			s.elapsed = tick_up(s.elapsed);
			if (s.elapsed >= regs.data_timeout) raise_error(s, ERR_TIMEOUT);
		end else if (is_frame && it.frame_kind == FK_DATA && it.frame_len >= MIN_DATA) begin
			if (it.frame_word[15:0] != s.exp_seq) begin
				raise_error(s, ERR_SEQ);
			end else begin
				note_action(ACT_WRITE, 32'(it.frame_len) - 32'(MIN_DATA));
				s.phase = PH_WAIT_WRITE;
			end
		end else if (is_frame && it.frame_kind == FK_END && it.frame_len >= MIN_SIZED) begin
			note_action(ACT_FINISH, it.frame_word);
			s.phase = PH_WAIT_FINISH;
		end
		PH_WAIT_WRITE: if (is_status) begin
			if (it.storage_status != ST_OK) begin
				raise_error(s, ERR_FLASH);
			end else begin
				s.exp_seq = s.exp_seq + 1'b1;
				s.elapsed = '0;
				s.phase   = PH_RECV;
			end
		end
		PH_WAIT_FINISH: if (is_status) begin
			if (it.storage_status == ST_OK) begin
				note_action(ACT_DONE, '0);
				note_action(ACT_SYSRESET, '0);
				s.phase = PH_DONE;
			end else if (it.storage_status == ST_SIZE_BAD) begin
				raise_error(s, ERR_SIZE);
			end else if (it.storage_status == ST_CRC_BAD) begin
				raise_error(s, ERR_CRC);
			end else begin
				raise_error(s, ERR_FLASH);
			end
		end
		default: ;
		endcase
		if (step_actions.size() != 0) begin
			tail      = step_actions.pop_back();
			tail.last = 1'b1;
			step_actions.push_back(tail);
		end
	endfunction

	function automatic in_item_t pack_item(input req_t r, input frame_kind_t k,
			input logic [7:0] len, input logic [31:0] word, input logic [2:0] st);
		in_item_t it;
		it.req_type       = r;
		it.frame_kind     = k;
		it.frame_len      = len;
		it.frame_word     = word;
		it.storage_status = st;
		return it;
	endfunction

	function automatic logic [31:0] pick_size();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel < 5) return $urandom_range(1, regs.max_image);
		else if (sel < 6) return regs.max_image;
		else if (sel < 7) return 32'd1;
		else if (sel < 8) return '0;
		else if (regs.max_image == '1) return $urandom;
		else return $urandom_range(regs.max_image + 1, 32'hFFFF_FFFF);
	endfunction

	// mostly well-formed traffic for the phase the block will be in, some noise
	function automatic in_item_t compose_item(input seq_state_t p, input logic allow_done);
		in_item_t    it;
		int unsigned roll;
		it.req_type       = 2'($urandom_range(0, 3));
		it.frame_kind     = 2'($urandom_range(0, 3));
		it.frame_len      = 8'($urandom);
		it.frame_word     = $urandom;
		it.storage_status = 3'($urandom_range(0, 7));
		roll = $urandom_range(0, 99);
		case (p.phase)
		PH_IDLE: if (roll < 88) it.req_type = REQ_TICK;
		PH_WAIT_ACK: if (roll < 75) begin
			it = pack_item(REQ_FRAME, FK_ACK, 8'($urandom_range(MIN_SIZED, 255)),
				pick_size(), it.storage_status);
		end else if (roll < 87) begin
			it.req_type = REQ_TICK;
		end
		PH_WAIT_ERASE, PH_WAIT_WRITE: if (roll < 85) begin
			it.req_type       = REQ_STATUS;
			it.storage_status = (roll < 75) ? ST_OK : 3'($urandom_range(1, 7));
		end
		PH_RECV: if (roll < 65) begin
			it = pack_item(REQ_FRAME, FK_DATA, 8'($urandom_range(MIN_DATA, 255)),
				{16'($urandom), p.exp_seq}, it.storage_status);
		end else if (roll < 71) begin
			it = pack_item(REQ_FRAME, FK_DATA, 8'($urandom_range(MIN_DATA, 255)),
				{16'($urandom), p.exp_seq ^ 16'($urandom_range(1, 65535))},
				it.storage_status);
		end else if (roll < 82) begin
			it = pack_item(REQ_FRAME, FK_END, 8'($urandom_range(MIN_SIZED, 255)),
				$urandom, it.storage_status);
		end else if (roll < 88) begin
			it.req_type = REQ_TICK;
		end
		PH_WAIT_FINISH: if (roll < 85) begin
			it.req_type = REQ_STATUS;
			if (allow_done && roll < 50) it.storage_status = ST_OK;
			else if (roll < 35) it.storage_status = ST_CRC_BAD;
			else it.storage_status = 3'($urandom_range(1, 7));
		end
		default: ;
		endcase
		// keep the image unfinished until the closing part of the run
		if (!allow_done && p.phase == PH_WAIT_FINISH && it.req_type == REQ_STATUS &&
				it.storage_status == ST_OK)
			it.storage_status = ST_CRC_BAD;
		return it;
	endfunction

	function automatic void queue_item(input in_item_t it);
		pending_items.push_back(it);
		step_actions.delete();
		advance_sequencer(plan, it);
	endfunction

	task automatic report(input string msg);
		if (error_count < 40) $display("ERROR cycle %0d: %s", cycles, msg);
		error_count++;
	endtask

	task automatic check_action(input logic [3:0] act, input logic [31:0] val, input logic lst);
		out_entry_t want;
		actions_checked++;
		if (act == ACT_ERROR) error_actions++;
		if (act == ACT_DONE) images_done++;
		if (expected_actions.size() == 0) begin
			report($sformatf("unexpected action %0d value %0h last %0b", act, val, lst));
		end else begin
			want = expected_actions.pop_front();
			if (act != want.action || val != want.value || lst != want.last)
				report($sformatf("action %0d value %0h last %0b, wanted %0d %0h %0b",
					act, val, lst, want.action, want.value, want.last));
		end
	endtask

	task automatic drain();
		while (pending_items.size() != 0 || offer || expected_actions.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic program_registers(input logic [23:0] ack, input logic [23:0] data,
			input logic [23:0] backoff, input logic [3:0] limit, input logic [31:0] max_img);
		logic [31:0] vals [5];
		vals[0] = {8'd0, ack};
		vals[1] = {8'd0, data};
		vals[2] = {8'd0, backoff};
		vals[3] = {28'd0, limit};
		vals[4] = max_img;
		for (int i = 0; i < 5; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= cfg_idx_t'(i);
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ch.ready);
			case (cfg_idx_t'(i))
			CFG_ACK_TIMEOUT:  regs.ack_timeout  = vals[i][TICK_W-1:0];
			CFG_DATA_TIMEOUT: regs.data_timeout = vals[i][TICK_W-1:0];
			CFG_BACKOFF:      regs.backoff      = vals[i][TICK_W-1:0];
			CFG_CRC_LIMIT:    regs.crc_limit    = vals[i][3:0];
			CFG_MAX_IMAGE:    regs.max_image    = vals[i];
			default: ;
			endcase
			reg_writes++;
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic random_items(input int unsigned count);
		for (int unsigned n = 0; n < count; n++) queue_item(compose_item(plan, 1'b0));
	endtask

	// sender
	always @(posedge clk) begin
		if (!arst_n) begin
			offer    <= 1'b0;
			gap_left <= 0;
		end else begin
			if (offer && req_ch.ready) begin
				step_actions.delete();
				advance_sequencer(live, offer_item);
				foreach (step_actions[i]) expected_actions.push_back(step_actions[i]);
				items_accepted++;
			end
			if (!offer || req_ch.ready) begin
				if (gap_left != 0) begin
					offer    <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_items.size() != 0 && !calm && $urandom_range(0, 9) == 0) begin
					offer    <= 1'b0;
					gap_left <= $urandom_range(0, 5);
				end else if (pending_items.size() != 0) begin
					offer      <= 1'b1;
					offer_item <= pending_items.pop_front();
				end else begin
					offer <= 1'b0;
				end
			end
		end
	end

	// long hold-off of the result channel
	always @(posedge clk) begin
		if (hold_go && !held_once) begin
			hold_left <= HOLD_CYCLES;
			held_once <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		if (!arst_n) begin
			accept_res <= 1'b0;
			stall_left <= 0;
		end else begin
			if (res_ch.valid && accept_res)
				check_action(res_ch.action, res_ch.action_value, res_ch.last_action);
			if (hold_left != 0) begin
				accept_res <= 1'b0;
			end else if (stall_left != 0) begin
				accept_res <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				accept_res <= 1'b0;
				stall_left <= $urandom_range(0, 5);
			end else begin
				accept_res <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d actions outstanding", cycles,
				expected_actions.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int unsigned tries;
		regs.ack_timeout  = 24'd5000;
		regs.data_timeout = 24'd30000;
		regs.backoff      = 24'd5000;
		regs.crc_limit    = 4'd3;
		regs.max_image    = 32'd2097152;
		plan       = '0;
		plan.phase = PH_IDLE;
		live       = plan;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed, default registers
		queue_item(pack_item(REQ_TICK, FK_ACK, 8'd0, 32'd0, ST_OK));
		queue_item(pack_item(REQ_FRAME, FK_ACK, 8'd3, 32'd100, ST_OK));
		queue_item(pack_item(REQ_NONE, FK_ACK, 8'd4, 32'd100, ST_OK));
		queue_item(pack_item(REQ_STATUS, FK_ACK, 8'd4, 32'd100, ST_OK));
		queue_item(pack_item(REQ_FRAME, FK_ACK, 8'd4, regs.max_image, ST_OK));
		queue_item(pack_item(REQ_TICK, FK_ACK, 8'd0, 32'd0, ST_OK));
		queue_item(pack_item(REQ_STATUS, FK_ACK, 8'd0, 32'd0, ST_OK));
		queue_item(pack_item(REQ_FRAME, FK_DATA, 8'd1, 32'd0, ST_OK));
		queue_item(pack_item(REQ_FRAME, FK_OTHER, 8'd255, 32'hFFFF_FFFF, ST_ODD_CODE));
		queue_item(pack_item(REQ_FRAME, FK_DATA, 8'd255, 32'hFFFF_0000, ST_OK));
		queue_item(pack_item(REQ_STATUS, FK_ACK, 8'd0, 32'd0, ST_OK));
		queue_item(pack_item(REQ_FRAME, FK_DATA, 8'd2, 32'd2, ST_OK));
		drain();

		// zero crc limit, no backoff, largest image
		program_registers(24'd2, 24'd3, 24'd0, 4'd0, 32'hFFFF_FFFF);
		queue_item(pack_item(REQ_TICK, FK_ACK, 8'd0, 32'd0, ST_OK));
		queue_item(pack_item(REQ_FRAME, FK_ACK, 8'd4, 32'hFFFF_FFFF, ST_OK));
		queue_item(pack_item(REQ_STATUS, FK_ACK, 8'd0, 32'd0, ST_OK));
		queue_item(pack_item(REQ_FRAME, FK_END, 8'd3, 32'd7, ST_OK));
		queue_item(pack_item(REQ_FRAME, FK_END, 8'd4, 32'h5A5A_A5A5, ST_OK));
		queue_item(pack_item(REQ_TICK, FK_ACK, 8'd0, 32'd0, ST_OK));
		queue_item(pack_item(REQ_STATUS, FK_ACK, 8'd0, 32'd0, ST_CRC_BAD));
		queue_item(pack_item(REQ_TICK, FK_ACK, 8'd0, 32'd0, ST_OK));
		queue_item(pack_item(REQ_FRAME, FK_ACK, 8'd4, 32'd0, ST_FLAG_BAD));
		queue_item(pack_item(REQ_TICK, FK_ACK, 8'd0, 32'd0, ST_OK));
		queue_item(pack_item(REQ_TICK, FK_ACK, 8'd0, 32'd0, ST_WRITE_BAD));
		queue_item(pack_item(REQ_TICK, FK_ACK, 8'd0, 32'd0, ST_OK));
		drain();

		program_registers(24'd3, 24'd4, 24'd2, 4'd3, 32'd1000);
		random_items(110);
		drain();

		// smallest settings, result channel held off while transactions keep coming
		program_registers(24'd1, 24'd1, 24'd1, 4'd1, 32'd1);
		random_items(70);
		hold_go <= 1'b1;
		drain();

		program_registers(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 4'd15, 32'h8000_0000);
		random_items(35);
		drain();

		program_registers(24'd5, 24'd6, 24'd3, 4'd2, $urandom_range(1, 32'hFFFF_FFFF));
		random_items(150);
		drain();

		// closing part: no idling, run on to a finished image, then inputs are ignored
		calm  <= 1'b1;
		tries = 0;
		while (plan.phase != PH_DONE && tries < 150) begin
			queue_item(compose_item(plan, 1'b1));
			tries++;
		end
		random_items(6);
		drain();
		repeat (SETTLE) @(posedge clk);

		$display("covered %0d transactions, %0d actions checked, %0d register writes",
			items_accepted, actions_checked, reg_writes);
		$display("error actions seen %0d, images finished %0d, mismatches %0d",
			error_actions, images_done, error_count);
		if (error_count == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule
